[rtl/schur_reflection_coefficients_macros.svh]
// Assertion helpers for the Schur block checker.
`ifndef SCHUR_REFLECTION_COEFFICIENTS_MACROS_SVH
`define SCHUR_REFLECTION_COEFFICIENTS_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/scr_pkg.sv]
package scr_pkg;

	localparam int ORDER_DEF  = 8;
	localparam int IN_W       = 32;
	localparam int GEN_W      = 40;
	localparam int Q_W        = 16;
	localparam int ERR_W      = 31;
	localparam int IDX_W      = 3;
	localparam int FRAC       = 15;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_G_RD,
		ST_G_LAT,
		ST_DIV_GO,
		ST_DIV,
		ST_MUL,
		ST_EMIT,
		ST_U_RD,
		ST_U_MUL,
		ST_U_WR
	} scr_state_t;

	typedef struct packed {
		logic           done;
		logic [Q_W-1:0] q;
	} div_res_t;

endpackage

[rtl/scr_mem.sv]
module scr_mem #(
	parameter int DEPTH = scr_pkg::ORDER_DEF,
	parameter int AW    = 3,
	parameter int W     = scr_pkg::GEN_W
) (
	input  logic          clk,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          ren,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/scr_div.sv]
// Rounded, saturating quotient: min(round(mag*2^15/dvsr), 32768).
// A start registers the operands, then one quotient bit per cycle; a saturated result skips the bits.
module scr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [scr_pkg::GEN_W-1:0]  mag,
	input  logic [scr_pkg::ERR_W-1:0]  dvsr,
	output scr_pkg::div_res_t          res
);
	import scr_pkg::*;

	localparam int NUM_W = GEN_W + FRAC + 1;
	localparam int REM_W = ERR_W + FRAC;
	localparam int CNT_W = $clog2(FRAC);

	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] lim;
	logic             sat;
	logic             ge;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sat_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsr_q;
	logic [FRAC-1:0]  quo_q;

	assign num = NUM_W'({mag, {FRAC{1'b0}}}) + NUM_W'(dvsr >> 1);
	assign lim = NUM_W'({dvsr, {FRAC{1'b0}}});
	assign sat = (num >= lim);
	assign ge  = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(FRAC - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= sat;
			rem_q <= REM_W'(num);
			dsr_q <= REM_W'({dvsr, {(FRAC-1){1'b0}}});
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[FRAC-2:0], ge};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign res.done = done_q;
	assign res.q    = sat_q ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, quo_q};
endmodule

[rtl/schur_reflection_coefficients.sv]
// Schur recursion, reflection coefficients in Q15 from ORDER+1 autocorrelation lags.
// Loading: one lag per cycle; the last lag starts the recursion and s_tready drops.
// Per stage i: G_RD, G_LAT, DIV_GO, DIV (skipped for a non-positive error), MUL and EMIT, then
// ORDER-1-i generator read-modify-writes (U_RD, U_MUL, U_WR), one entry pair each via the row memories.
// Stage 0 gives the first result; next frame loads once the last beat is registered.
// arst_n clears control state only; the row memories keep stale data, always rewritten.
module schur_reflection_coefficients #(
	parameter int ORDER = scr_pkg::ORDER_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave beat: [31:0] autocorr_value
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [scr_pkg::IN_W-1:0]       s_tdata,
	// master beat: [2:0] coef_index, [18:3] reflection, [49:19] residual_error, zero pad
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [scr_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] zero_energy
	output logic                           m_tuser,
	// is_last
	output logic                           m_tlast
);
	import scr_pkg::*;

	localparam int AW     = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int CNT_W  = $clog2(ORDER + 1);
	localparam int PROD_W = GEN_W + Q_W;
	localparam int RND_W  = PROD_W + 1 - FRAC;
	localparam int SUM_W  = RND_W + 1;
	localparam int EW     = IN_W;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (GEN_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(64'sd1 <<< (GEN_W - 1)));
	localparam logic signed [SUM_W-1:0] ERR_HI = SUM_W'((64'sd1 <<< ERR_W) - 1);

	// rnd15: floor((p + 2^14) / 2^15)
	function automatic logic signed [RND_W-1:0] rnd15(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		t = $signed({p[PROD_W-1], p}) + $signed((PROD_W + 1)'(1 << (FRAC - 1)));
		return RND_W'(t >>> FRAC);
	endfunction

	function automatic logic signed [GEN_W-1:0] sat40(input logic signed [SUM_W-1:0] x);
		if (x > SAT_HI) begin
			return SAT_HI[GEN_W-1:0];
		end else if (x < SAT_LO) begin
			return SAT_LO[GEN_W-1:0];
		end
		return x[GEN_W-1:0];
	endfunction

	scr_state_t state_q, state_d;

	logic [CNT_W-1:0]        cnt_q;
	logic [AW-1:0]           i_q;
	logic [AW-1:0]           m_q;
	logic signed [EW-1:0]    err_q;
	logic                    zero_q;
	logic signed [GEN_W-1:0] g_q;
	logic signed [Q_W-1:0]   r_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] pu_q;
	logic signed [PROD_W-1:0] pl_q;

	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic [Q_W-1:0]          out_refl_q;
	logic [ERR_W-1:0]        out_err_q;
	logic                    out_zero_q;
	logic                    out_last_q;

	// row memory ports
	logic                    wen;
	logic [AW-1:0]           waddr;
	logic [GEN_W-1:0]        up_wdata, lo_wdata;
	logic                    up_ren, lo_ren;
	logic [AW-1:0]           up_raddr, lo_raddr;
	logic signed [GEN_W-1:0] up_rdata, lo_rdata;

	logic                    div_start;
	div_res_t                div_res;

	logic                    in_fire;
	logic                    out_free;
	logic                    err_pos;
	logic                    g_pos;
	logic                    g_neg;
	logic [GEN_W-1:0]        g_mag;
	logic signed [Q_W-1:0]   r_new;
	logic signed [SUM_W-1:0] err_sum;
	logic [ERR_W-1:0]        err_new;
	logic                    last_stage;
	logic                    more_upd;

	assign in_fire    = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign err_pos    = !err_q[EW-1] && (err_q != '0);
	assign g_neg      = g_q[GEN_W-1];
	assign g_pos      = !g_neg && (g_q != '0);
	assign g_mag      = g_neg ? GEN_W'(-g_q) : GEN_W'(g_q);
	assign last_stage = (i_q == AW'(ORDER - 1));
	// another entry left while m+1 < ORDER-1-i
	assign more_upd   = ((AW + 1)'(m_q) + (AW + 1)'(i_q) + (AW + 1)'(1)) < (AW + 1)'(ORDER - 1);

	// r = -min(q,32768) for positive g, else min(q,32767)
	always_comb begin
		if (g_pos) begin
			r_new = Q_W'(-$signed({1'b0, div_res.q}));
		end else if (div_res.q[Q_W-1]) begin
			r_new = {1'b0, {(Q_W-1){1'b1}}};
		end else begin
			r_new = $signed(div_res.q);
		end
	end

	always_comb begin
		err_sum = SUM_W'(err_q) + SUM_W'(rnd15(prod_q));
		if (err_sum < 0) begin
			err_new = '0;
		end else if (err_sum > ERR_HI) begin
			err_new = ERR_HI[ERR_W-1:0];
		end else begin
			err_new = err_sum[ERR_W-1:0];
		end
	end

	scr_mem #(.DEPTH(ORDER), .AW(AW), .W(GEN_W)) u_upper (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (up_wdata),
		.ren   (up_ren),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	scr_mem #(.DEPTH(ORDER), .AW(AW), .W(GEN_W)) u_lower (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (lo_wdata),
		.ren   (lo_ren),
		.raddr (lo_raddr),
		.rdata (lo_rdata)
	);

	scr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (g_mag),
		.dvsr   (err_q[ERR_W-1:0]),
		.res    (div_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_fire && cnt_q == CNT_W'(ORDER)) begin
					state_d = ST_G_RD;
				end
			end
			ST_G_RD:   state_d = ST_G_LAT;
			ST_G_LAT:  state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = err_pos ? ST_DIV : ST_MUL;
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:    state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = last_stage ? ST_LOAD : ST_U_RD;
				end
			end
			ST_U_RD:   state_d = ST_U_MUL;
			ST_U_MUL:  state_d = ST_U_WR;
			ST_U_WR:   state_d = more_upd ? ST_U_RD : ST_G_RD;
			default:   state_d = ST_LOAD;
		endcase
	end

	// memory and divider controls
	always_comb begin
		s_tready  = 1'b0;
		wen       = 1'b0;
		waddr     = m_q;
		up_wdata  = sat40(SUM_W'(up_rdata) + SUM_W'(rnd15(pl_q)));
		lo_wdata  = sat40(SUM_W'(lo_rdata) + SUM_W'(rnd15(pu_q)));
		up_ren    = 1'b0;
		lo_ren    = 1'b0;
		up_raddr  = m_q;
		lo_raddr  = m_q + 1'b1;
		div_start = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				wen      = s_tvalid && (cnt_q != '0);
				waddr    = AW'(cnt_q - 1'b1);
				up_wdata = GEN_W'($signed(s_tdata));
				lo_wdata = GEN_W'($signed(s_tdata));
			end
			ST_G_RD: begin
				lo_ren   = 1'b1;
				lo_raddr = '0;
			end
			ST_DIV_GO: div_start = err_pos;
			ST_U_RD: begin
				up_ren = 1'b1;
				lo_ren = 1'b1;
			end
			ST_U_WR:   wen = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			i_q         <= '0;
			m_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new beat loads when the register is empty or as the old one leaves
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (cnt_q == CNT_W'(ORDER)) begin
							cnt_q <= '0;
							i_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_q <= '0;
					end
				end
				ST_U_WR: begin
					if (more_upd) begin
						m_q <= m_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (in_fire && cnt_q == '0) begin
					err_q  <= $signed(s_tdata);
					zero_q <= (s_tdata == '0);
				end
			end
			ST_G_LAT:  g_q <= lo_rdata;
			ST_DIV_GO: begin
				if (!err_pos) begin
					r_q <= '0;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					r_q <= r_new;
				end
			end
			ST_MUL:    prod_q <= g_q * r_q;
			ST_EMIT: begin
				if (out_free) begin
					err_q      <= EW'(err_new);
					out_idx_q  <= IDX_W'(i_q);
					out_refl_q <= r_q;
					out_err_q  <= err_new;
					out_zero_q <= zero_q;
					out_last_q <= last_stage;
				end
			end
			ST_U_MUL: begin
				pu_q <= r_q * up_rdata;
				pl_q <= r_q * lo_rdata;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_err_q, out_refl_q, out_idx_q});
	assign m_tuser  = out_zero_q;
	assign m_tlast  = out_last_q;
endmodule

[rtl/scr_chk.sv]
`include "schur_reflection_coefficients_macros.svh"

module scr_chk #(
	parameter int ORDER = scr_pkg::ORDER_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [scr_pkg::IN_W-1:0]       s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [scr_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser,
	input logic                           m_tlast
);
	import scr_pkg::*;

	`SCR_ASSERT_IMP(a_in_known, s_tvalid && s_tready, !$isunknown(s_tdata), "input beat has unknown data")
	`SCR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")
	`SCR_ASSERT_IMP(a_zero_frame, m_tvalid && m_tuser, m_tdata[49:3] == '0, "zero-energy beat not zero")
	`SCR_ASSERT_IMP(a_last_idx, m_tvalid && m_tlast, m_tdata[2:0] == IDX_W'(ORDER - 1), "last on wrong stage")
endmodule

bind schur_reflection_coefficients scr_chk #(.ORDER(ORDER)) u_scr_chk (.*);
